// ===== rtl/markov_pitch_class_sampler_top_defines.svh =====
// Assertion macros for the pitch-class sampler RTL.
// Included by mpcs_ctrl, which checks its own control logic; no other dependencies.
`ifndef MARKOV_PITCH_CLASS_SAMPLER_TOP_DEFINES_SVH
`define MARKOV_PITCH_CLASS_SAMPLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MPCS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mpcs assertion failed");
`define MPCS_ASSERT_ANY(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("mpcs assertion failed");
`else
`define MPCS_ASSERT(lbl, clk, rst_n, prop)
`define MPCS_ASSERT_ANY(lbl, clk, prop)
`endif
`endif

// ===== rtl/mpcs_pkg.sv =====
// Shared types, constants and helpers for the pitch-class sampler.
// No dependencies; imported by every RTL module of the block.
package mpcs_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int NUM_CLASSES = 12;
	localparam int CLASS_BITS  = $clog2(NUM_CLASSES);
	localparam int TBL_DEPTH   = NUM_CLASSES * NUM_CLASSES;
	localparam int ADDR_BITS   = $clog2(TBL_DEPTH);
	localparam int SUM_BITS    = COUNT_BITS + CLASS_BITS;
	localparam int WORD_BITS   = 32;
	localparam int PROD_BITS   = WORD_BITS + SUM_BITS;
	localparam int NOTE_BITS   = 7;
	localparam int OCT_BITS    = 4;

	// reciprocal for note / NUM_CLASSES, exact over all 7-bit notes
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_BITS  = RECIP_SHIFT + 1;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + NUM_CLASSES - 1) / NUM_CLASSES;

	typedef enum logic [1:0] {
		OP_TRAIN  = 2'd0,
		OP_GEN    = 2'd1,
		OP_GEN_AT = 2'd2,
		OP_SET    = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [NOTE_BITS-1:0]   note;
		logic                   restart;
		logic [WORD_BITS-1:0]   random_word;
	} in_item_t;

	typedef struct packed {
		logic [NOTE_BITS-1:0] next_note;
		logic                 row_empty;
	} out_item_t;

	typedef struct packed {
		logic load_in;
		logic rd_pair;
		logic wr_pair;
		logic set_cur;
		logic clr_row;
		logic rd_row;
		logic mul;
		logic emit;
	} mpcs_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    idx_last;
	} mpcs_sts_t;

	// note mod NUM_CLASSES through a reciprocal multiply
	function automatic logic [CLASS_BITS-1:0] class_of(input logic [NOTE_BITS-1:0] n);
		logic [NOTE_BITS+RECIP_BITS-1:0] p;
		logic [NOTE_BITS-1:0]            q;
		logic [NOTE_BITS-1:0]            r;
		p = (NOTE_BITS+RECIP_BITS)'(n) * (NOTE_BITS+RECIP_BITS)'(RECIP);
		q = p[RECIP_SHIFT +: NOTE_BITS];
		r = n - NOTE_BITS'(q * NOTE_BITS'(NUM_CLASSES));
		return CLASS_BITS'(r);
	endfunction

endpackage

// ===== rtl/markov_pitch_class_sampler_top.sv =====
// Top level of the first-order Markov pitch-class sampler.
// Depends on mpcs_pkg, mpcs_ctrl and mpcs_dp.
//
//   port group   dir   beat contents
//   in_*         in    opcode, note, restart, random_word (in_item_t)
//   out_*        out   next_note, row_empty (out_item_t), one beat per draw
//   cfg_*        in    octave, written whenever cfg_valid is high
//
// A new item is not taken until the last is done: train reads then writes one
// count, set current note ends at decode, and draw reads the count row one entry
// per cycle from the table memory, scales and picks, plus any wait for out_ready.
// Reset: ready out of reset; per-entry valid flags make the whole table read
// as zero, so there is no clearing pass.
// A result waiting in the output register does not block the next input beat;
// only the next draw waits for it to be taken.
module markov_pitch_class_sampler_top import mpcs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [OCT_BITS-1:0] cfg_data
);

	mpcs_cmd_t cmd;
	mpcs_sts_t sts;

	// the octave register can take a write on every cycle
	assign cfg_ready = 1'b1;

	// sequence each beat: decode, then either a read-modify-write of one count, or
	// a row sweep, a scaling multiply and a parallel pick, or nothing more for a set
	mpcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold the table, the class registers and the result register
	mpcs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.cfg_wr   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule

// ===== rtl/mpcs_dp.sv =====
// Datapath of the pitch-class sampler: count table, row sum, draw and result register.
// Depends on mpcs_pkg; driven by mpcs_ctrl through mpcs_cmd_t.
module mpcs_dp import mpcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpcs_cmd_t            cmd,
	output mpcs_sts_t            sts,
	input  in_item_t             in_data,
	input  logic                 cfg_wr,
	input  logic [OCT_BITS-1:0]  cfg_data,
	output out_item_t            out_data
);

	in_item_t              in_q;
	logic [OCT_BITS-1:0]   octave_q;
	logic [CLASS_BITS-1:0] cur_q;
	logic [CLASS_BITS-1:0] prev_q;
	logic [CLASS_BITS-1:0] idx_q;
	logic [CLASS_BITS-1:0] idx_s1;
	logic                  acc_s1;
	logic [SUM_BITS-1:0]   sum_q;
	logic [SUM_BITS-1:0]   pre_q [NUM_CLASSES];
	logic [PROD_BITS-1:0]  prod_q;
	logic                  empty_q;
	out_item_t             out_q;

	logic [COUNT_BITS-1:0] mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0]  vld_q;
	logic [COUNT_BITS-1:0] rd_s1;
	logic                  rdv_s1;

	logic [CLASS_BITS-1:0] cls;
	logic [CLASS_BITS-1:0] prev_sel;
	logic [ADDR_BITS-1:0]  pair_addr;
	logic [ADDR_BITS-1:0]  row_addr;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic [COUNT_BITS-1:0] rd_val;
	logic [COUNT_BITS-1:0] inc_val;
	logic [SUM_BITS-1:0]   run_sum;
	logic [SUM_BITS-1:0]   hi;
	logic [CLASS_BITS-1:0] pick;
	logic [NOTE_BITS-1:0]  note_out;

	assign cls       = class_of(in_q.note);
	assign prev_sel  = in_q.restart ? '0 : prev_q;
	assign pair_addr = ADDR_BITS'(prev_sel) * ADDR_BITS'(NUM_CLASSES) + ADDR_BITS'(cls);
	assign row_addr  = ADDR_BITS'(cur_q) * ADDR_BITS'(NUM_CLASSES) + ADDR_BITS'(idx_q);
	assign rd_addr   = cmd.rd_pair ? pair_addr : row_addr;

	// never-written entries read as zero
	assign rd_val  = rdv_s1 ? rd_s1 : '0;
	assign inc_val = (rd_val == '1) ? rd_val : rd_val + COUNT_BITS'(1);
	assign run_sum = sum_q + SUM_BITS'(rd_val);

	// scaled draw minus one: first class whose running sum exceeds it wins
	assign hi = prod_q[WORD_BITS +: SUM_BITS];

	always_comb begin
		pick = '0;
		for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
			if (pre_q[j] > hi) begin
				pick = CLASS_BITS'(j);
			end
		end
	end

	assign note_out = NOTE_BITS'(pick) + NOTE_BITS'(octave_q) * NOTE_BITS'(NUM_CLASSES);

	always_ff @(posedge clk) begin
		if (cmd.wr_pair) begin
			mem[pair_addr] <= inc_val;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q <= '0;
			cur_q    <= '0;
			prev_q   <= '0;
			acc_s1   <= 1'b0;
			vld_q    <= '0;
			rdv_s1   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				octave_q <= cfg_data;
			end
			if (cmd.emit) begin
				cur_q <= pick;
			end else if (cmd.set_cur) begin
				cur_q <= cls;
			end
			if (cmd.wr_pair) begin
				prev_q           <= cls;
				vld_q[pair_addr] <= 1'b1;
			end
			acc_s1 <= cmd.rd_row;
			rdv_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_data;
		end
		if (cmd.clr_row) begin
			idx_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.rd_row) begin
				idx_q <= idx_q + CLASS_BITS'(1);
			end
			if (acc_s1) begin
				sum_q         <= run_sum;
				pre_q[idx_s1] <= run_sum;
			end
		end
		idx_s1 <= idx_q;
		if (cmd.mul) begin
			prod_q  <= PROD_BITS'(in_q.random_word) * PROD_BITS'(sum_q);
			empty_q <= (sum_q == '0);
		end
		if (cmd.emit) begin
			out_q.next_note <= note_out;
			out_q.row_empty <= empty_q;
		end
	end

	assign sts.opcode   = in_q.opcode;
	assign sts.idx_last = (idx_q == CLASS_BITS'(NUM_CLASSES - 1));
	assign out_data     = out_q;

endmodule

// ===== rtl/mpcs_ctrl.sv =====
// Controller of the pitch-class sampler: sequences train, set and draw operations.
// Depends on mpcs_pkg and the assertion macro header; commands mpcs_dp.
`include "markov_pitch_class_sampler_top_defines.svh"
module mpcs_ctrl import mpcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  mpcs_sts_t sts,
	output mpcs_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TRAIN_WR,
		ST_SUM,
		ST_DRAIN,
		ST_MUL,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
			end
			ST_DECODE: begin
				case (sts.opcode)
					OP_TRAIN:  cmd.rd_pair = 1'b1;
					OP_GEN:    cmd.clr_row = 1'b1;
					OP_GEN_AT: begin
						cmd.clr_row = 1'b1;
						cmd.set_cur = 1'b1;
					end
					OP_SET:    cmd.set_cur = 1'b1;
					default:   cmd.set_cur = 1'b0;
				endcase
			end
			ST_TRAIN_WR: cmd.wr_pair = 1'b1;
			ST_SUM:      cmd.rd_row  = 1'b1;
			ST_MUL:      cmd.mul     = 1'b1;
			ST_EMIT:     cmd.emit    = slot_free;
			default:     cmd.emit    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !cmd.emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_DECODE;
						in_ready_q <= 1'b0;
					end
				end
				ST_DECODE: begin
					case (sts.opcode)
						OP_TRAIN:          state_q <= ST_TRAIN_WR;
						OP_GEN, OP_GEN_AT: state_q <= ST_SUM;
						default: begin
							state_q    <= ST_IDLE;
							in_ready_q <= 1'b1;
						end
					endcase
				end
				ST_TRAIN_WR: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
				ST_SUM: begin
					if (sts.idx_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (slot_free) begin
						state_q     <= ST_IDLE;
						in_ready_q  <= 1'b1;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	`MPCS_ASSERT(a_ready_idle, clk, arst_n, in_ready_q == (state_q == ST_IDLE))
	`MPCS_ASSERT(a_accept_decode, clk, arst_n, (in_valid && in_ready_q) |=> (state_q == ST_DECODE))
	`MPCS_ASSERT(a_emit_from_emit, clk, arst_n, cmd.emit |-> (state_q == ST_EMIT && slot_free))
	`MPCS_ASSERT(a_sum_ends, clk, arst_n, (state_q == ST_SUM && sts.idx_last) |=> (state_q == ST_DRAIN))

endmodule
